[src/lowest_free_slot_allocator_macros.svh]
// assertion macros for the lowest free slot allocator checker
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_MACROS_SVH

// check held off while reset is high
`define LFSA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lfsa check failed");

// check that also runs through reset
`define LFSA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lfsa check failed");

`endif

[src/lfsa_pkg.sv]
// shared constants, codes and control types of the slot allocator
package lfsa_pkg;

  localparam int OWNERS      = 1024;
  localparam int SLOTS       = 1024;
  localparam int OWNER_W     = $clog2(OWNERS);
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int WORD_W      = 32;
  localparam int LSB_W       = $clog2(WORD_W);
  localparam int BM_WORDS    = SLOTS / WORD_W;
  localparam int BM_IDX_W    = $clog2(BM_WORDS);
  localparam int HOLD_WORDS  = OWNERS / WORD_W;
  localparam int HOLD_IDX_W  = $clog2(HOLD_WORDS);
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((OWNER_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SLOT_W + 1 + 7) / 8) * 8;

  // command codes
  localparam logic CMD_CLAIM   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL          = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_RELEASE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic issue;      // transfer taken: latch owner, start reads
    logic rel_rd;     // read occupancy word of the held slot
    logic claim_fin;  // finish a claim into the output register
    logic rel_fin;    // finish a release into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_room;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

[src/lfsa_ctrl.sv]
// sequencing state machine of the slot allocator
module lfsa_ctrl import lfsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  output ctl_cmd_t cmd,
  input  dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLAIM,
    S_REL_CHK,
    S_REL_FIN
  } state_t;

  state_t state;

  always_comb begin
    in_ready      = (state == S_IDLE) && !rst;
    cmd           = '0;
    cmd.issue     = in_ready && in_valid;
    cmd.rel_rd    = (state == S_REL_CHK);
    cmd.claim_fin = (state == S_CLAIM) && stat.out_room;
    cmd.rel_fin   = (state == S_REL_FIN) && stat.out_room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (in_cmd == CMD_RELEASE) ? S_REL_CHK : S_CLAIM;
          end
        end
        S_CLAIM: begin
          if (stat.out_room) state <= S_IDLE;
        end
        S_REL_CHK: begin
          state <= S_REL_FIN;
        end
        S_REL_FIN: begin
          if (stat.out_room) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/lfsa_dp.sv]
// occupancy bitmap, owner tables and result register of the slot allocator
module lfsa_dp import lfsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic [OWNER_W-1:0]  in_owner,
  input  logic                cfg_valid,
  input  logic [OWNER_W-1:0]  cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_watched,
  output logic [STATUS_W-1:0] out_status
);

  // memories
  logic [WORD_W-1:0] bm_mem   [BM_WORDS];
  logic [WORD_W-1:0] hold_mem [HOLD_WORDS];
  logic [SLOT_W-1:0] oslot_mem [OWNERS];

  // row valid bits and word summary
  logic [BM_WORDS-1:0]   bm_row_valid;
  logic [HOLD_WORDS-1:0] hold_row_valid;
  logic [BM_WORDS-1:0]   summary_full;

  logic [OWNER_W-1:0] watched_owner;

  // operation registers
  logic [OWNER_W-1:0]  op_owner;
  logic                claim_ok;
  logic [BM_IDX_W-1:0] bm_idx;
  logic [WORD_W-1:0]   bm_rd_data;
  logic                bm_rd_valid;
  logic [WORD_W-1:0]   hold_rd_data;
  logic                hold_rd_valid;
  logic [SLOT_W-1:0]   oslot_rd;

  logic [BM_IDX_W-1:0] free_word_idx;
  logic                any_free;
  logic [LSB_W-1:0]    free_bit;
  logic [BM_IDX_W-1:0] bm_ra;
  logic [WORD_W-1:0]   bm_word;
  logic [WORD_W-1:0]   hold_word;
  logic [WORD_W-1:0]   claim_mask;
  logic [WORD_W-1:0]   rel_mask;
  logic [WORD_W-1:0]   hold_mask;
  logic                held;
  logic                claim_do;
  logic                rel_do;
  logic                bm_we;
  logic [WORD_W-1:0]   bm_wd;
  logic [WORD_W-1:0]   hold_wd;

  // lowest word with a free slot
  always_comb begin
    free_word_idx = '0;
    any_free      = 1'b0;
    for (int i = BM_WORDS - 1; i >= 0; i--) begin
      if (!summary_full[i]) begin
        free_word_idx = BM_IDX_W'(i);
        any_free      = 1'b1;
      end
    end
  end

  assign bm_word   = bm_rd_valid ? bm_rd_data : '0;
  assign hold_word = hold_rd_valid ? hold_rd_data : '0;

  // lowest free bit in the fetched word
  always_comb begin
    free_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!bm_word[i]) free_bit = LSB_W'(i);
    end
  end

  assign bm_ra      = cmd.issue ? free_word_idx : oslot_rd[SLOT_W-1:LSB_W];
  assign claim_mask = WORD_W'(1) << free_bit;
  assign rel_mask   = WORD_W'(1) << oslot_rd[LSB_W-1:0];
  assign hold_mask  = WORD_W'(1) << op_owner[LSB_W-1:0];
  assign held       = hold_word[op_owner[LSB_W-1:0]];
  assign claim_do   = cmd.claim_fin && claim_ok;
  assign rel_do     = cmd.rel_fin && held;
  assign bm_we      = claim_do || rel_do;
  assign bm_wd      = claim_do ? (bm_word | claim_mask) : (bm_word & ~rel_mask);
  assign hold_wd    = claim_do ? (hold_word | hold_mask) : (hold_word & ~hold_mask);

  assign stat.out_room = !out_valid || out_ready;

  // operand capture and registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op_owner      <= in_owner;
      claim_ok      <= any_free;
      hold_rd_data  <= hold_mem[in_owner[OWNER_W-1:LSB_W]];
      hold_rd_valid <= hold_row_valid[in_owner[OWNER_W-1:LSB_W]];
      oslot_rd      <= oslot_mem[in_owner];
    end
    if (cmd.issue || cmd.rel_rd) begin
      bm_idx      <= bm_ra;
      bm_rd_data  <= bm_mem[bm_ra];
      bm_rd_valid <= bm_row_valid[bm_ra];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_idx] <= bm_wd;
      hold_mem[op_owner[OWNER_W-1:LSB_W]] <= hold_wd;
    end
    if (claim_do) begin
      oslot_mem[op_owner] <= {bm_idx, free_bit};
    end
  end

  // control state of the bitmap and the owner flags
  always_ff @(posedge clk) begin
    if (rst) begin
      bm_row_valid   <= '0;
      hold_row_valid <= '0;
      summary_full   <= '0;
      watched_owner  <= '0;
    end else begin
      if (cfg_valid) watched_owner <= cfg_data;
      if (bm_we) begin
        bm_row_valid[bm_idx]                      <= 1'b1;
        hold_row_valid[op_owner[OWNER_W-1:LSB_W]] <= 1'b1;
      end
      if (claim_do) begin
        summary_full[bm_idx] <= &(bm_word | claim_mask);
      end else if (rel_do) begin
        summary_full[bm_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.claim_fin || cmd.rel_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim_fin) begin
      out_slot    <= claim_ok ? {bm_idx, free_bit} : '0;
      out_watched <= claim_ok && (op_owner == watched_owner);
      out_status  <= claim_ok ? ST_OK : ST_FULL;
    end else if (cmd.rel_fin) begin
      out_slot    <= held ? oslot_rd : '0;
      out_watched <= 1'b0;
      out_status  <= held ? ST_OK : ST_EMPTY_RELEASE;
    end
  end

endmodule

[src/lowest_free_slot_allocator.sv]
// top level of the lowest free slot allocator
// Hands out and takes back slots 0..1023 for owners 0..1023. A claim transfer
// (tuser 0) gives the owner the lowest free slot; a release transfer (tuser 1)
// frees the slot recorded for the owner. Each input transfer yields exactly one
// result transfer carrying the slot, a watched flag and a status (ok, no free
// slot, release by an owner holding nothing). Events must arrive in time order
// with releases ahead of claims of the same time. One event is in work at a
// time: a claim passes through the claim state, a release through the release
// check and release finish states, and the controller is back in idle as the
// result is written to the output register; a stalled result holds the
// controller until the output register frees up. These steps are set by the
// registered read port of the occupancy bitmap memory (32 words of 32 slots,
// with a per-word full summary kept in flip-flops) and, for a release, the
// extra read of the owner's recorded slot before its occupancy word. A
// finished result waits in the output register while the next event is taken.
// No clearing pass is needed after reset: row valid bits make untouched words
// read as empty. The watched owner register may be written whenever the block
// is idle and is ready whenever reset is low.
module lowest_free_slot_allocator import lfsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input events
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // owner_id, zero fill
  input  logic [0:0]             s_axis_tuser,   // cmd
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // slot_number, is_watched, zero fill
  output logic [STATUS_W-1:0]    m_axis_tuser,   // status
  // watched owner register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OWNER_W-1:0]     cfg_data
);

  ctl_cmd_t            cmd;
  dp_stat_t            stat;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_watched;

  // register write completes in one transfer once out of reset
  assign cfg_ready = !rst;

  lfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lfsa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_owner    (s_axis_tdata[OWNER_W-1:0]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_slot    (out_slot),
    .out_watched (out_watched),
    .out_status  (m_axis_tuser)
  );

  // pack result fields, lowest bit first
  assign m_axis_tdata = {{(OUT_TDATA_W - SLOT_W - 1){1'b0}}, out_watched, out_slot};

endmodule

[src/lfsa_checker.sv]
// port level checks of the slot allocator and their binding
`include "lowest_free_slot_allocator_macros.svh"

module lfsa_checker import lfsa_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]    m_axis_tuser
);

  // nothing comes out straight after reset
  `LFSA_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_axis_tvalid)

  // one event in work at a time
  `LFSA_ASSERT(a_one_at_a_time, clk, rst,
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

  // a failed event carries neither slot nor watched flag
  `LFSA_ASSERT(a_fail_clean, clk, rst,
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[SLOT_W:0] == '0))

  // only defined status codes
  `LFSA_ASSERT(a_status_code, clk, rst,
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
                       m_axis_tuser == ST_EMPTY_RELEASE))

  // a stalled result holds
  `LFSA_ASSERT(a_out_hold, clk, rst,
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the lowest free slot allocator, claim and release traffic against a predictor
module tb;
  import lfsa_pkg::*;

  localparam int IDLE_LIMIT = 4000;  // cycles with no transfer before the run is given up
  localparam int LONG_HOLD  = 300;   // receiver hold-off that backs the block up
  localparam int MAX_PRINTS = 40;

  // one result as the allocator should answer it
  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic                watched;
    logic [STATUS_W-1:0] status;
  } grant_t;

  // occupancy predictor and store of answers still due
  class slot_scoreboard;
    bit                 busy [SLOTS];
    logic [SLOT_W-1:0]  held_slot [OWNERS];
    bit                 holds [OWNERS];
    logic [OWNER_W-1:0] watched_owner;
    int                 busy_count;
    grant_t             due_q[$];
    int errors, n_events, n_granted, n_released, n_full, n_empty_rel, n_watched;

    function new();
      foreach (busy[i]) busy[i] = 1'b0;
      foreach (holds[i]) begin
        holds[i]     = 1'b0;
        held_slot[i] = '0;
      end
      watched_owner = '0;
      busy_count    = 0;
    endfunction

    function void set_watched(logic [OWNER_W-1:0] v);
      watched_owner = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // accepted input event: advance the occupancy map and queue the answer
    function void note_event(logic cmd, logic [OWNER_W-1:0] owner);
      grant_t g;
      int     s;
      g.slot    = '0;
      g.watched = 1'b0;
      g.status  = ST_OK;
      n_events++;
      if (cmd == CMD_CLAIM) begin
        s = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!busy[i]) begin
            s = i;
            break;
          end
        if (s < 0) begin
          g.status = ST_FULL;
          n_full++;
        end else begin
          // a second claim by a holder leaks the earlier slot
          busy[s]          = 1'b1;
          busy_count++;
          held_slot[owner] = SLOT_W'(s);
          holds[owner]     = 1'b1;
          g.slot           = SLOT_W'(s);
          g.watched        = (owner == watched_owner);
          n_granted++;
          if (g.watched) n_watched++;
        end
      end else if (!holds[owner]) begin
        g.status = ST_EMPTY_RELEASE;
        n_empty_rel++;
      end else begin
        busy[held_slot[owner]] = 1'b0;
        busy_count--;
        holds[owner] = 1'b0;
        g.slot       = held_slot[owner];
        n_released++;
      end
      due_q.push_back(g);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // accepted result transfer against the oldest answer due
    task check_result(logic [SLOT_W-1:0] slot, logic watched, logic [STATUS_W-1:0] status);
      grant_t g;
      if (due_q.size() == 0) begin
        report_mismatch("result with nothing due, slot", int'(slot), -1);
      end else begin
        g = due_q.pop_front();
        if (slot !== g.slot) report_mismatch("slot_number", int'(slot), int'(g.slot));
        if (watched !== g.watched)
          report_mismatch("is_watched", int'(watched), int'(g.watched));
        if (status !== g.status) report_mismatch("status", int'(status), int'(g.status));
      end
    endtask

    // random owner that currently holds a slot, -1 when nobody does
    function int pick_holder();
      int start;
      start = $urandom_range(0, OWNERS - 1);
      for (int i = 0; i < OWNERS; i++)
        if (holds[(start + i) % OWNERS]) return (start + i) % OWNERS;
      return -1;
    endfunction

    // random owner, preferably one holding nothing
    function int pick_idle_owner();
      int o;
      o = $urandom_range(0, OWNERS - 1);
      for (int i = 0; i < 8 && holds[o]; i++) o = $urandom_range(0, OWNERS - 1);
      return o;
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // owner_id, zero fill
  logic [0:0]             s_axis_tuser = '0;   // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // slot_number, is_watched, zero fill
  logic [STATUS_W-1:0]    m_axis_tuser;        // status
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [OWNER_W-1:0]     cfg_data = '0;

  slot_scoreboard sb = new();

  bit src_steady    = 1'b0;  // sender offers back to back
  bit sink_steady   = 1'b0;  // receiver always ready
  bit long_hold_req = 1'b0;  // receiver to begin a long hold-off
  int n_long_holds  = 0;
  int n_cfg_writes  = 0;
  int idle_cycles   = 0;

  lowest_free_slot_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer, after a random gap unless the sender runs steady
  task automatic send_event(logic cmd, int owner);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(owner);
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_event(cmd, OWNER_W'(owner));
  endtask

  // sender goes quiet until every answer due has been taken
  task automatic pause_until_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // watched owner write, only with the block idle
  task automatic write_watched(int v);
    pause_until_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= OWNER_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_watched(OWNER_W'(v));
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // claimer: sometimes the watched owner, sometimes a holder claiming again
  function automatic int pick_claimer();
    int r, h;
    r = $urandom_range(0, 99);
    if (r < 10) return int'(sb.watched_owner);
    if (r < 18) begin
      h = sb.pick_holder();
      if (h >= 0) return h;
    end
    return sb.pick_idle_owner();
  endfunction

  // mostly well-formed traffic: claims, releases by holders, and stray releases
  task automatic mixed_event(int claim_pct, int release_pct);
    int r, h;
    r = $urandom_range(0, 99);
    if (r < claim_pct) begin
      send_event(CMD_CLAIM, pick_claimer());
    end else if (r < claim_pct + release_pct) begin
      h = sb.pick_holder();
      send_event(CMD_RELEASE, (h >= 0) ? h : $urandom_range(0, OWNERS - 1));
    end else begin
      send_event(CMD_RELEASE, $urandom_range(0, OWNERS - 1));
    end
  endtask

  // receiver: random stalls, steady stretches and a long hold-off on each request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD - 1;
        n_long_holds++;
        m_axis_tready <= 1'b0;
      end else if (sink_steady || $urandom_range(0, 99) < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) stall_left--;
        m_axis_tready <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[SLOT_W-1:0], m_axis_tdata[SLOT_W], m_axis_tuser);

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty release, grants from slot 0, double claim, reuse of the lowest hole
    send_event(CMD_RELEASE, 0);          // nothing held yet
    send_event(CMD_CLAIM, 0);            // watched owner after reset is 0
    send_event(CMD_CLAIM, OWNERS - 1);
    send_event(CMD_CLAIM, 0);            // second claim leaks slot 0
    send_event(CMD_RELEASE, 0);          // frees the later slot only
    send_event(CMD_RELEASE, 0);          // now holds nothing
    send_event(CMD_CLAIM, 5);            // takes the hole left above
    send_event(CMD_RELEASE, OWNERS - 1);
    send_event(CMD_CLAIM, 10'h2AA);
    send_event(CMD_CLAIM, 10'h155);
    send_event(CMD_RELEASE, 10'h2AA);
    send_event(CMD_RELEASE, 10'h155);
    write_watched(OWNERS - 1);
    send_event(CMD_CLAIM, OWNERS - 1);
    send_event(CMD_CLAIM, 0);            // owner 0 no longer watched
    send_event(CMD_RELEASE, OWNERS - 1);
    send_event(CMD_CLAIM, OWNERS - 1);
    send_event(CMD_RELEASE, 5);

    // mixed traffic with a long receiver hold-off against a steady sender
    write_watched($urandom_range(1, OWNERS - 2));
    for (int k = 0; k < 250; k++) begin
      if (k == 60) begin
        long_hold_req = 1'b1;
        src_steady    = 1'b1;
      end
      if (k == 90) src_steady = 1'b0;
      if (k == 150) begin
        src_steady  = 1'b1;
        sink_steady = 1'b1;
      end
      if (k == 200) begin
        src_steady  = 1'b0;
        sink_steady = 1'b0;
      end
      mixed_event(55, 40);
    end

    // fill every slot, then keep claiming against a full map
    write_watched(0);
    long_hold_req = 1'b1;
    while (sb.busy_count < SLOTS) send_event(CMD_CLAIM, pick_claimer());
    repeat (30) send_event(CMD_CLAIM, pick_claimer());

    // release-heavy traffic out of the full state
    write_watched(OWNERS - 1);
    repeat (250) mixed_event(30, 60);

    write_watched($urandom_range(0, OWNERS - 1));
    repeat (100) mixed_event(50, 45);

    pause_until_drained();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch("answers never delivered", 0, sb.pending());

    $display("covered %0d events: %0d grants, %0d releases, %0d full, %0d empty releases",
             sb.n_events, sb.n_granted, sb.n_released, sb.n_full, sb.n_empty_rel);
    $display("watched grants %0d over %0d register writes, %0d long receiver hold-offs",
             sb.n_watched, n_cfg_writes, n_long_holds);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
